### rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants of the I2C master transfer sequencer
// Command classes, command and result records, control op and mask codes.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int CMDQ_DEPTH      = 4;
  localparam int OFFSET_W        = 16;
  localparam int CFG_DATA_W      = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_TARGET_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_READ_NOT_WRITE  = 2'd1;
  localparam logic [1:0] CFG_RESTART_FOLLOWS = 2'd2;
  localparam logic [1:0] CFG_TRANSFER_LENGTH = 2'd3;

  // status flag bit positions
  localparam int FLAG_START_SENT = 0;
  localparam int FLAG_ADDR_SENT  = 1;
  localparam int FLAG_TX_EMPTY   = 2;
  localparam int FLAG_BYTE_DONE  = 3;
  localparam int FLAG_RX_FULL    = 4;

  // controller operations
  localparam logic [5:0] OP_NONE  = 6'h00;
  localparam logic [5:0] OP_START = 6'h01;
  localparam logic [5:0] OP_ACK   = 6'h02;
  localparam logic [5:0] OP_NACK  = 6'h04;
  localparam logic [5:0] OP_STOP  = 6'h08;
  localparam logic [5:0] OP_POS   = 6'h10;
  localparam logic [5:0] OP_SWRST = 6'h20;

  // interrupt enable masks
  localparam logic [2:0] IRQ_NONE   = 3'd0;
  localparam logic [2:0] IRQ_NO_BUF = 3'd6;
  localparam logic [2:0] IRQ_ALL    = 3'd7;

  // variant codes carried next to the command class
  localparam logic [1:0] VAR_NONE      = 2'd0;
  localparam logic [1:0] VAR_ADDR_ONE  = 2'd1;  // single-byte read
  localparam logic [1:0] VAR_ADDR_TWO  = 2'd2;  // two-byte read
  localparam int         VAR_START_RD  = 1;     // start: read direction
  localparam int         VAR_START_BIG = 0;     // start: read of more than two
  localparam int         VAR_END_STOP  = 0;     // write end: issue stop

  typedef enum logic [3:0] {
    CMD_START,
    CMD_IDLE,
    CMD_ADDR,
    CMD_ADDR_SENT,
    CMD_TX,
    CMD_TX_END,
    CMD_RX_PAIR_DONE,
    CMD_RX_ONE,
    CMD_RX_LAST_THREE,
    CMD_RX_FINAL,
    CMD_FAIL
  } cmd_class_t;

  typedef struct packed {
    logic [6:0]  target_address;
    logic        read_not_write;
    logic        restart_follows;
    logic [15:0] transfer_length;
  } cfg_t;

  typedef struct packed {
    cmd_class_t          cls;
    logic [1:0]          variant;
    logic [7:0]          dr_value;
    logic [7:0]          rx_a;
    logic [7:0]          rx_b;
    logic [OFFSET_W-1:0] offset;
  } cmd_t;

  typedef struct packed {
    logic                dr_write_en;
    logic [7:0]          dr_write_value;
    logic [5:0]          control_ops;
    logic                irq_mask_write_en;
    logic [2:0]          irq_mask;
    logic [1:0]          rx_count;
    logic [OFFSET_W-1:0] byte_offset;
    logic [7:0]          rx_byte_a;
    logic [7:0]          rx_byte_b;
    logic                done_res;
    logic                success;
  } res_t;

endpackage

### rtl/i2c_master_transfer_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top: I2C master transfer sequencer
// Turns start requests and controller events into controller writes,
// received bytes to store, and transfer completion.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | beat
//  ---------+----------------------+----------------------------------------
//  item in  | push / full          | kind, start_pending, status_flags,
//           |                      | tx_data, rx_first, rx_second
//  result   | pop / empty          | dr_write_*, control_ops, irq_mask*,
//           |                      | rx_count, byte_offset, rx_byte_*,
//           |                      | done_res, success
//  config   | cfg_write            | cfg_index, cfg_data
//
// One beat in per cycle while the queue is not full, one result beat per item.
// The classifier settles the item and the byte offset in the cycle it is
// accepted; the result passes a queue slot, then the result register.
// The command queue holds CMDQ_DEPTH beats, so a stalled result side pushes
// back on full only after the queue and the result register are taken.
// Reset (rst, synchronous) empties the queue and result register and clears
// the offset and all configuration registers.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top #(
  parameter int LENGTH_BITS = i2cms_pkg::LENGTH_BITS_DEF,
  parameter int CMDQ_DEPTH  = i2cms_pkg::CMDQ_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]  cfg_data,
  // item in
  input  logic                              push,
  output logic                              full,
  input  logic                              kind,
  input  logic                              start_pending,
  input  logic [4:0]                        status_flags,
  input  logic [7:0]                        tx_data,
  input  logic [7:0]                        rx_first,
  input  logic [7:0]                        rx_second,
  // result
  output logic                              empty,
  input  logic                              pop,
  output logic                              dr_write_en,
  output logic [7:0]                        dr_write_value,
  output logic [5:0]                        control_ops,
  output logic                              irq_mask_write_en,
  output logic [2:0]                        irq_mask,
  output logic [1:0]                        rx_count,
  output logic [i2cms_pkg::OFFSET_W-1:0]    byte_offset,
  output logic [7:0]                        rx_byte_a,
  output logic [7:0]                        rx_byte_b,
  output logic                              done_res,
  output logic                              success
);
  import i2cms_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  res_t res;
  logic accept;
  logic queue_empty;
  logic queue_pop;
  logic res_valid;

  // Hold configuration; users write only while idle; the block does not check.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TARGET_ADDRESS:  cfg.target_address  <= cfg_data[6:0];
        CFG_READ_NOT_WRITE:  cfg.read_not_write  <= cfg_data[0];
        CFG_RESTART_FOLLOWS: cfg.restart_follows <= cfg_data[0];
        CFG_TRANSFER_LENGTH: cfg.transfer_length <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Accept a beat whenever the command queue has room.
  assign accept = push && !full;

  i2cms_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cfg           (cfg),
    .kind          (kind),
    .start_pending (start_pending),
    .status_flags  (status_flags),
    .tx_data       (tx_data),
    .rx_first      (rx_first),
    .rx_second     (rx_second),
    .cmd           (front_cmd)
  );

  // Decouple classification from execution.
  i2cms_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .full      (full),
    .pop       (queue_pop),
    .pop_data  (queue_cmd),
    .empty     (queue_empty)
  );

  // Expand commands to result beats; advance when the result is empty or taken.
  i2cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (queue_cmd),
    .cmd_empty (queue_empty),
    .cmd_pop   (queue_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty             = !res_valid;
  assign dr_write_en       = res.dr_write_en;
  assign dr_write_value    = res.dr_write_value;
  assign control_ops       = res.control_ops;
  assign irq_mask_write_en = res.irq_mask_write_en;
  assign irq_mask          = res.irq_mask;
  assign rx_count          = res.rx_count;
  assign byte_offset       = res.byte_offset;
  assign rx_byte_a         = res.rx_byte_a;
  assign rx_byte_b         = res.rx_byte_b;
  assign done_res          = res.done_res;
  assign success           = res.success;

endmodule

### rtl/i2cms_front.sv
// ----------------------------------------------------------------------------
// i2cms_front: item classifier
// Sorts each accepted item into a command class and keeps the byte offset.
// ----------------------------------------------------------------------------
module i2cms_front #(
  parameter int LENGTH_BITS = i2cms_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  i2cms_pkg::cfg_t   cfg,
  input  logic              kind,
  input  logic              start_pending,
  input  logic [4:0]        status_flags,
  input  logic [7:0]        tx_data,
  input  logic [7:0]        rx_first,
  input  logic [7:0]        rx_second,
  output i2cms_pkg::cmd_t   cmd
);
  import i2cms_pkg::*;

  logic [LENGTH_BITS-1:0] offset;
  logic [LENGTH_BITS-1:0] offset_next;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS:0]   diff;
  logic                   rem_neg;
  logic [LENGTH_BITS-1:0] rem;
  logic                   rem_is1;
  logic                   rem_is3;
  logic                   rem_over3;
  logic                   len_is1;
  logic                   len_is2;
  logic                   len_over2;
  logic                   plain_read;
  logic                   plain_write;

  assign len       = cfg.transfer_length[LENGTH_BITS-1:0];
  assign diff      = {1'b0, len} - {1'b0, offset};
  assign rem_neg   = diff[LENGTH_BITS];
  assign rem       = diff[LENGTH_BITS-1:0];
  assign rem_is1   = !rem_neg && (rem == LENGTH_BITS'(1));
  assign rem_is3   = !rem_neg && (rem == LENGTH_BITS'(3));
  assign rem_over3 = !rem_neg && (rem > LENGTH_BITS'(3));
  assign len_is1   = (len == LENGTH_BITS'(1));
  assign len_is2   = (len == LENGTH_BITS'(2));
  assign len_over2 = (len > LENGTH_BITS'(2));

  assign plain_read  = cfg.read_not_write && !cfg.restart_follows;
  assign plain_write = !cfg.read_not_write && !cfg.restart_follows;

  always_comb begin
    cmd         = '0;
    cmd.cls     = CMD_FAIL;
    cmd.variant = VAR_NONE;
    cmd.rx_a    = rx_first;
    cmd.rx_b    = rx_second;
    cmd.offset  = OFFSET_W'(offset);
    offset_next = offset;
    if (!kind) begin
      cmd.cls                   = CMD_START;
      cmd.offset                = '0;
      cmd.variant[VAR_START_RD]  = cfg.read_not_write;
      cmd.variant[VAR_START_BIG] = cfg.read_not_write && len_over2;
      offset_next               = '0;
    end else if (start_pending) begin
      cmd.cls = CMD_IDLE;
    end else if (status_flags[FLAG_START_SENT]) begin
      cmd.cls      = CMD_ADDR;
      cmd.dr_value = {cfg.target_address, cfg.read_not_write};
    end else if (status_flags[FLAG_ADDR_SENT]) begin
      cmd.cls = CMD_ADDR_SENT;
      if (plain_read && len_is1) begin
        cmd.variant = VAR_ADDR_ONE;
      end else if (plain_read && len_is2) begin
        cmd.variant = VAR_ADDR_TWO;
      end
    end else if (status_flags[FLAG_TX_EMPTY]) begin
      if (offset < len) begin
        cmd.cls      = CMD_TX;
        cmd.dr_value = tx_data;
        offset_next  = offset + LENGTH_BITS'(1);
      end else begin
        cmd.cls                   = CMD_TX_END;
        cmd.variant[VAR_END_STOP] = plain_write;
      end
    end else if (status_flags[FLAG_BYTE_DONE] && len_is2) begin
      cmd.cls     = CMD_RX_PAIR_DONE;
      offset_next = offset + LENGTH_BITS'(2);
    end else if (status_flags[FLAG_BYTE_DONE] && len_over2 && rem_over3) begin
      cmd.cls     = CMD_RX_ONE;
      offset_next = offset + LENGTH_BITS'(1);
    end else if (status_flags[FLAG_BYTE_DONE] && len_over2 && rem_is3) begin
      cmd.cls     = CMD_RX_LAST_THREE;
      offset_next = offset + LENGTH_BITS'(2);
    end else if (status_flags[FLAG_RX_FULL] && len_is1) begin
      cmd.cls    = CMD_RX_FINAL;
      cmd.offset = '0;
    end else if (status_flags[FLAG_RX_FULL] && len_is2) begin
      cmd.cls = CMD_IDLE;
    end else if (status_flags[FLAG_RX_FULL] && rem_is1) begin
      cmd.cls     = CMD_RX_FINAL;
      offset_next = offset + LENGTH_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (accept) begin
      offset <= offset_next;
    end
  end

endmodule

### rtl/i2cms_cmdq.sv
// ----------------------------------------------------------------------------
// i2cms_cmdq: command queue
// Small first-in first-out store between the classifier and the executor.
// ----------------------------------------------------------------------------
module i2cms_cmdq #(
  parameter int DEPTH = i2cms_pkg::CMDQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  i2cms_pkg::cmd_t  push_data,
  output logic             full,
  input  logic             pop,
  output i2cms_pkg::cmd_t  pop_data,
  output logic             empty
);
  import i2cms_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/i2cms_back.sv
// ----------------------------------------------------------------------------
// i2cms_back: command executor
// Expands a command into controller writes and holds the result register.
// ----------------------------------------------------------------------------
module i2cms_back (
  input  logic             clk,
  input  logic             rst,
  input  i2cms_pkg::cmd_t  cmd,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  output i2cms_pkg::res_t  res,
  output logic             res_valid,
  input  logic             res_pop
);
  import i2cms_pkg::*;

  res_t res_next;
  logic load;

  assign load    = !cmd_empty && (!res_valid || res_pop);
  assign cmd_pop = load;

  always_comb begin
    res_next             = '0;
    res_next.byte_offset = cmd.offset;
    case (cmd.cls)
      CMD_START: begin
        res_next.irq_mask_write_en = 1'b1;
        res_next.irq_mask    = cmd.variant[VAR_START_BIG] ? IRQ_NO_BUF : IRQ_ALL;
        res_next.control_ops = cmd.variant[VAR_START_RD] ? (OP_START | OP_ACK) : OP_START;
      end
      CMD_IDLE: begin
      end
      CMD_ADDR, CMD_TX: begin
        res_next.dr_write_en    = 1'b1;
        res_next.dr_write_value = cmd.dr_value;
      end
      CMD_ADDR_SENT: begin
        case (cmd.variant)
          VAR_ADDR_ONE: res_next.control_ops = OP_NACK | OP_STOP;
          VAR_ADDR_TWO: res_next.control_ops = OP_POS | OP_NACK;
          default:      res_next.control_ops = OP_NONE;
        endcase
      end
      CMD_TX_END: begin
        res_next.control_ops       = cmd.variant[VAR_END_STOP] ? OP_STOP : OP_NONE;
        res_next.irq_mask_write_en = 1'b1;
        res_next.irq_mask          = IRQ_NONE;
        res_next.done_res          = 1'b1;
        res_next.success           = 1'b1;
      end
      CMD_RX_PAIR_DONE: begin
        res_next.control_ops       = OP_STOP;
        res_next.rx_count          = 2'd2;
        res_next.rx_byte_a         = cmd.rx_a;
        res_next.rx_byte_b         = cmd.rx_b;
        res_next.irq_mask_write_en = 1'b1;
        res_next.irq_mask          = IRQ_NONE;
        res_next.done_res          = 1'b1;
        res_next.success           = 1'b1;
      end
      CMD_RX_ONE: begin
        res_next.rx_count  = 2'd1;
        res_next.rx_byte_a = cmd.rx_a;
      end
      CMD_RX_LAST_THREE: begin
        // open the buffer interrupt for the last byte
        res_next.irq_mask_write_en = 1'b1;
        res_next.irq_mask          = IRQ_ALL;
        res_next.control_ops       = OP_NACK | OP_STOP;
        res_next.rx_count          = 2'd2;
        res_next.rx_byte_a         = cmd.rx_a;
        res_next.rx_byte_b         = cmd.rx_b;
      end
      CMD_RX_FINAL: begin
        res_next.rx_count          = 2'd1;
        res_next.rx_byte_a         = cmd.rx_a;
        res_next.irq_mask_write_en = 1'b1;
        res_next.irq_mask          = IRQ_NONE;
        res_next.done_res          = 1'b1;
        res_next.success           = 1'b1;
      end
      default: begin
        res_next.control_ops       = OP_SWRST;
        res_next.irq_mask_write_en = 1'b1;
        res_next.irq_mask          = IRQ_NONE;
        res_next.done_res          = 1'b1;
        res_next.success           = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule
